FILE: hdl/clock_synth_serial_programmer_top_assert.svh
// Assertion macros shared by the serial programmer RTL.
`ifndef CLOCK_SYNTH_SERIAL_PROGRAMMER_TOP_ASSERT_SVH
`define CLOCK_SYNTH_SERIAL_PROGRAMMER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CSP_ASSERT_NOW(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CSP_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: hdl/csp_pkg.sv
// Types and constants of the synthesizer serial programmer.
`default_nettype none
package csp_pkg;

    localparam int unsigned SEL_W   = 4;
    localparam int unsigned HZ_W    = 28;
    localparam int unsigned WORD_W  = 20;
    localparam int unsigned CNT_W   = 5;
    localparam int unsigned N_W     = 10;

    localparam logic [CNT_W-1:0] LAST_BIT = 5'd19;
    localparam logic [N_W-1:0]   N_OFFSET = 10'd257;

    // 143181818*N/460 = 71590909*N/230 = 311264*N + 189*N/230
    localparam logic [18:0] COARSE_MULT = 19'd311264;
    // floor(189*N/230) = (N * 189 * 72945) >> 24, exact for N <= 512
    localparam logic [23:0] FINE_MULT   = 24'd13786605;

    localparam int unsigned SEL_CLK  = 3;
    localparam int unsigned SEL_DATA = 2;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] word;
    } csp_frame_t;

    typedef struct packed {
        logic             en;
        logic [SEL_W-1:0] idx;
        logic [HZ_W-1:0]  hz;
    } csp_write_t;

endpackage
`default_nettype wire

FILE: hdl/csp_serial_port.sv
// Serial clock edge detect, frame shifter and bit counter.
`default_nettype none
`include "clock_synth_serial_programmer_top_assert.svh"
module csp_serial_port
    import csp_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             step,
    input  wire logic             strobe_req,
    input  wire logic [SEL_W-1:0] sel,
    output csp_frame_t            frame
);

    logic              in_frame_reg, in_frame_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic              last_clk_reg, last_clk_next;
    logic              rise;
    logic              done;

    assign rise = step && strobe_req && sel[SEL_CLK] && !last_clk_reg;

    always_comb begin
        in_frame_next = in_frame_reg;
        cnt_next      = cnt_reg;
        word_next     = word_reg;
        last_clk_next = last_clk_reg;
        done          = 1'b0;
        if (step && strobe_req) begin
            last_clk_next = sel[SEL_CLK];
        end
        if (rise) begin
            if (!in_frame_reg) begin
                in_frame_next = sel[SEL_DATA];
                cnt_next      = '0;
            end else begin
                word_next = {sel[SEL_DATA], word_reg[WORD_W-1:1]};
                cnt_next  = CNT_W'(cnt_reg + 5'd1);
                // twentieth bit closes the frame
                if (cnt_reg == LAST_BIT) begin
                    done          = 1'b1;
                    in_frame_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            cnt_reg      <= '0;
            word_reg     <= '0;
            last_clk_reg <= 1'b0;
        end else begin
            in_frame_reg <= in_frame_next;
            cnt_reg      <= cnt_next;
            word_reg     <= word_next;
            last_clk_reg <= last_clk_next;
        end
    end

    assign frame.done = done;
    assign frame.word = word_next;

    `CSP_ASSERT_NOW(a_cnt_range, aclk, aresetn, 1'b1, cnt_reg <= 5'd20,
        "bit counter past frame length")
    `CSP_ASSERT_NEXT(a_done_idle, aclk, aresetn, done, !in_frame_reg,
        "port still in frame after decode")
    `CSP_ASSERT_NEXT(a_no_step_hold, aclk, aresetn, !step,
        $stable(in_frame_reg) && $stable(cnt_reg) && $stable(last_clk_reg),
        "port state moved without a transfer")

endmodule
`default_nettype wire

FILE: hdl/csp_freq_calc.sv
// Frame word decode into table index and output frequency.
`default_nettype none
module csp_freq_calc
    import csp_pkg::*;
(
    input  wire csp_frame_t frame,
    output csp_write_t      wr
);

    logic [N_W-1:0]  n;
    logic [HZ_W-1:0] coarse;
    logic [32:0]     fine_prod;
    logic [HZ_W-1:0] base_hz;
    logic [1:0]      shift;

    assign n         = N_W'({2'b00, frame.word[14:7]}) + N_OFFSET;
    assign coarse    = HZ_W'(n) * HZ_W'(COARSE_MULT);
    assign fine_prod = 33'(n) * 33'(FINE_MULT);
    assign base_hz   = coarse + HZ_W'(fine_prod[32:24]);
    // divider code 0..3 selects 8, 4, 2, 1
    assign shift     = ~frame.word[17:16];

    assign wr.en  = frame.done;
    assign wr.idx = frame.word[5:2];
    assign wr.hz  = base_hz >> shift;

endmodule
`default_nettype wire

FILE: hdl/csp_freq_table.sv
// Sixteen-entry frequency table with write-through read.
`default_nettype none
module csp_freq_table
    import csp_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire csp_write_t       wr,
    input  wire logic [SEL_W-1:0] rd_sel,
    output logic [HZ_W-1:0]       rd_data
);

    localparam int unsigned DEPTH = 1 << SEL_W;

    logic [HZ_W-1:0] entry_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                entry_reg[i] <= '0;
            end
        end else if (wr.en) begin
            entry_reg[wr.idx] <= wr.hz;
        end
    end

    // forward this cycle's update to the read
    assign rd_data = (wr.en && wr.idx == rd_sel) ? wr.hz : entry_reg[rd_sel];

endmodule
`default_nettype wire

FILE: hdl/clock_synth_serial_programmer_top.sv
// Top level of the frequency-synthesizer serial programming port.
//
//  channel | ports                          | direction | transfer
//  --------+--------------------------------+-----------+--------------------
//  s_      | s_strobe_req, s_sel            | in        | s_valid & s_ready
//  m_      | m_output_clock_hz              | out       | m_valid & m_ready
//
// One transfer per cycle sustained while m_ready stays high; an input transfer
// reaches the result through the input register, then the result register.
// Port state, frame decode and table update run in the cycle an item leaves
// the input register; the result carries the table after that update.
// s_ready drops only while both registers are full and m_ready is low.
// aresetn clears the port state, the table and both valid flags.
`default_nettype none
`include "clock_synth_serial_programmer_top_assert.svh"
module clock_synth_serial_programmer_top
    import csp_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic             s_strobe_req,
    input  wire logic [SEL_W-1:0] s_sel,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [HZ_W-1:0]       m_output_clock_hz
);

    logic             in_valid_reg;
    logic             in_strobe_reg;
    logic [SEL_W-1:0] in_sel_reg;
    logic             out_valid_reg;
    logic [HZ_W-1:0]  out_hz_reg;
    logic             adv;
    logic             take;
    csp_frame_t       frame;
    csp_write_t       wr;
    logic [HZ_W-1:0]  rd_data;

    assign adv     = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || adv;
    assign take    = s_valid && s_ready;

    csp_serial_port u_port (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (adv),
        .strobe_req (in_strobe_reg),
        .sel        (in_sel_reg),
        .frame      (frame)
    );

    csp_freq_calc u_calc (
        .frame (frame),
        .wr    (wr)
    );

    csp_freq_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (wr),
        .rd_sel  (in_sel_reg),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                in_valid_reg <= 1'b1;
            end else if (adv) begin
                in_valid_reg <= 1'b0;
            end
            if (adv) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            in_strobe_reg <= s_strobe_req;
            in_sel_reg    <= s_sel;
        end
        if (adv) begin
            out_hz_reg <= rd_data;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_output_clock_hz = out_hz_reg;

    `CSP_ASSERT_NOW(a_stall_cause, aclk, aresetn, !s_ready,
        in_valid_reg && out_valid_reg && !m_ready, "input stalled without back-pressure")
    `CSP_ASSERT_NEXT(a_adv_result, aclk, aresetn, adv, out_valid_reg,
        "advanced item produced no result")
    `CSP_ASSERT_NEXT(a_hold_input, aclk, aresetn, in_valid_reg && !adv,
        in_valid_reg && $stable(in_sel_reg) && $stable(in_strobe_reg),
        "pending item lost or changed")

endmodule
`default_nettype wire

FILE: dv/clock_synth_serial_programmer_top_tb.sv
// Testbench for the synthesizer serial programming port: frame stimulus and result checking.
module clock_synth_serial_programmer_top_tb;
    import csp_pkg::*;

    localparam int unsigned FRAME_BITS = 20;
    localparam longint unsigned REF_HZ_X10 = 64'd143181818;
    localparam longint unsigned REF_DIV_X10 = 64'd460;
    localparam int unsigned TARGET_WRITES = 700;
    localparam int unsigned LONG_HOLD_AT = 300;
    localparam int unsigned LONG_HOLD_CYCLES = 120;

    typedef struct {
        logic             strobe;
        logic [SEL_W-1:0] sel;
        bit               drain;
    } port_write_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic             s_strobe_req = 1'b0;
    logic [SEL_W-1:0] s_sel = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [HZ_W-1:0]  m_output_clock_hz;

    // predictor copy of the port and the frequency table
    logic              pr_in_frame = 1'b0;
    logic [CNT_W-1:0]  pr_bit_count = '0;
    logic [WORD_W-1:0] pr_shift = '0;
    logic              pr_last_clk = 1'b0;
    logic [HZ_W-1:0]   pr_table [16];

    port_write_t     pending_writes [$];
    logic [HZ_W-1:0] expected_hz [$];
    bit              drain_next = 1'b0;

    port_write_t drv_item;
    int drv_gap = 0;
    int rcv_wait = 0;
    int rcv_hold = 0;
    int writes_sent = 0;
    int results_seen = 0;
    int frames_decoded = 0;
    int mismatches = 0;
    logic [HZ_W-1:0] exp_hz;

    clock_synth_serial_programmer_top u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_strobe_req      (s_strobe_req),
        .s_sel             (s_sel),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_output_clock_hz (m_output_clock_hz)
    );

    always #6 aclk = ~aclk;

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        for (int i = 0; i < 16; i++) pr_table[i] = '0;
    end

    // Apply one port write to the predicted state and return the answer for sel.
    function automatic logic [HZ_W-1:0] program_and_read(logic strobe, logic [SEL_W-1:0] sel);
        logic sclk;
        logic sdata;
        longint unsigned n;
        longint unsigned div;
        longint unsigned hz;
        sclk = sel[SEL_CLK];
        sdata = sel[SEL_DATA];
        if (strobe) begin
            if (sclk && !pr_last_clk) begin
                if (!pr_in_frame) begin
                    pr_in_frame = sdata;
                    pr_bit_count = '0;
                end else begin
                    pr_shift = {sdata, pr_shift[WORD_W-1:1]};
                    pr_bit_count = pr_bit_count + 1'b1;
                    if (pr_bit_count == FRAME_BITS) begin
                        n = 64'(pr_shift[14:7]) + 64'(N_OFFSET);
                        div = 64'd8 >> pr_shift[17:16];
                        hz = (REF_HZ_X10 * n) / (REF_DIV_X10 * div);
                        pr_table[pr_shift[5:2]] = hz[HZ_W-1:0];
                        pr_in_frame = 1'b0;
                        frames_decoded++;
                    end
                end
            end
            pr_last_clk = sclk;
        end
        return pr_table[sel];
    endfunction

    // Stretches of back-to-back traffic on both sides.
    function automatic bit no_idle(int count);
        return ((count / 80) % 4) == 1;
    endfunction

    task automatic add_write(logic strobe, logic [SEL_W-1:0] sel);
        port_write_t w;
        w.strobe = strobe;
        w.sel = sel;
        w.drain = drain_next;
        drain_next = 1'b0;
        pending_writes.push_back(w);
    endtask

    // Well-formed frame: low clock, start edge with data high, then twenty data edges.
    task automatic add_frame(logic [WORD_W-1:0] word, bit noisy);
        logic [SEL_W-1:0] r;
        r = 4'($urandom);
        r[SEL_CLK] = 1'b0;
        add_write(1'b1, r);
        r = 4'($urandom);
        r[SEL_CLK] = 1'b1;
        r[SEL_DATA] = 1'b1;
        add_write(1'b1, r);
        for (int i = 0; i < FRAME_BITS; i++) begin
            r = 4'($urandom);
            r[SEL_CLK] = 1'b0;
            add_write(1'b1, r);
            if (noisy && $urandom_range(0, 2) == 0) add_write(1'b0, 4'($urandom));
            r = 4'($urandom);
            r[SEL_CLK] = 1'b1;
            r[SEL_DATA] = word[i];
            add_write(1'b1, r);
            // repeat the high level: no edge, nothing shifts
            if (noisy && $urandom_range(0, 3) == 0) begin
                r[SEL_DATA] = 1'($urandom);
                add_write(1'b1, r);
            end
        end
    endtask

    initial begin
        // reads of the empty table, then edges that must not open a frame
        add_write(1'b0, 4'b0000);
        add_write(1'b0, 4'b1111);
        add_write(1'b1, 4'b0000);
        add_write(1'b1, 4'b1000);
        add_write(1'b1, 4'b1100);
        add_write(1'b0, 4'b0111);
        add_write(1'b1, 4'b1111);
        add_write(1'b1, 4'b0011);
        add_write(1'b0, 4'b1100);
        add_write(1'b1, 4'b0000);
        // highest and lowest settings
        add_frame({2'b11, 2'b11, 8'hff, 1'b1, 4'hf, 2'b11}, 1'b0);
        add_frame({2'b00, 2'b00, 8'h00, 1'b0, 4'h0, 2'b00}, 1'b1);
        add_write(1'b0, 4'b1111);
        add_write(1'b0, 4'b0000);
        while (pending_writes.size() < TARGET_WRITES) begin
            if (pending_writes.size() > 400 && !drain_next && writes_sent == 0
                    && frames_decoded == 0)
                drain_next = 1'b1;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: add_frame(20'($urandom), $urandom_range(0, 2) == 0);
                6, 7: begin
                    repeat ($urandom_range(2, 6)) add_write(1'b0, 4'($urandom));
                end
                default: begin
                    repeat ($urandom_range(3, 10)) add_write(1'($urandom), 4'($urandom));
                end
            endcase
        end

        while (pending_writes.size() != 0 || s_valid || expected_hz.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        $display("Sent %0d port writes, decoded %0d frames, checked %0d frequencies.",
                 writes_sent, frames_decoded, results_seen);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #1500000;
        $display("TB_ERROR");
        $finish;
    end

    // Sender: hold the payload until the transfer, then idle a drawn number of cycles.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            drv_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_hz.push_back(program_and_read(drv_item.strobe, drv_item.sel));
                writes_sent++;
                drv_gap = no_idle(writes_sent) ? 0 : $urandom_range(0, 4);
            end
            if (!s_valid || s_ready) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                    s_valid <= 1'b0;
                end else if (pending_writes.size() != 0
                        && (!pending_writes[0].drain || expected_hz.size() == 0)) begin
                    drv_item = pending_writes.pop_front();
                    s_valid <= 1'b1;
                    s_strobe_req <= drv_item.strobe;
                    s_sel <= drv_item.sel;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each transfer against the oldest predicted frequency.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rcv_wait = 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_hz.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, actual %0d",
                             $time, m_output_clock_hz);
                end else begin
                    exp_hz = expected_hz.pop_front();
                    if (m_output_clock_hz !== exp_hz) begin
                        mismatches++;
                        $display("%0t: output_clock_hz mismatch, expected %0d, actual %0d",
                                 $time, exp_hz, m_output_clock_hz);
                    end
                end
                rcv_wait = no_idle(results_seen) ? 0 : $urandom_range(0, 4);
                // hold off long enough for the block to fill and stall its input
                if (results_seen == LONG_HOLD_AT) rcv_hold = LONG_HOLD_CYCLES;
            end
            if (rcv_hold > 0) begin
                rcv_hold--;
                m_ready <= 1'b0;
            end else if (rcv_wait > 0) begin
                rcv_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

endmodule
